// ----- rtl/hc3_pkg.sv -----
package hc3_pkg;

   localparam int BLOCK_SIZE = 3;

   localparam int LETTER_W = 5;
   localparam int SUM_W    = 11;   // three products of 25 * 25 at most: 1875
   localparam int CHAR_W   = 7;
   localparam int KEY_W    = BLOCK_SIZE * LETTER_W;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [LETTER_W-1:0] ALPHA_LEN = 5'd26;
   localparam logic [LETTER_W-1:0] PAD_VALUE = 5'd23;   // 'X'
   localparam logic [CHAR_W-1:0]   LETTER_A  = 7'd65;

   localparam logic [7:0] UPPER_A = 8'd65;
   localparam logic [7:0] UPPER_Z = 8'd90;
   localparam logic [7:0] LOWER_A = 8'd97;
   localparam logic [7:0] LOWER_Z = 8'd122;

   // floor(x / 26) == (x * RECIP_26) >> RECIP_SHIFT for every x below 2048
   localparam logic [11:0] RECIP_26    = 12'd2521;
   localparam int          RECIP_SHIFT = 16;
   localparam int          PROD_W      = SUM_W + 12;
   localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

   typedef enum logic [1:0] {
      REG_KEY_ROW_ZERO = 2'd0,
      REG_KEY_ROW_ONE  = 2'd1,
      REG_KEY_ROW_TWO  = 2'd2,
      REG_NONE         = 2'd3
   } reg_index_type;

   // one block of plaintext letters on its way to the multiplier stage
   typedef struct packed {
      logic [BLOCK_SIZE-1:0][LETTER_W-1:0] p;
      logic                                empty;
      logic                                done;
   } blk_type;

   // row sums, before the mod 26
   typedef struct packed {
      logic [BLOCK_SIZE-1:0][SUM_W-1:0] sum;
      logic                             empty;
      logic                             done;
   } sum_type;

   function automatic logic [LETTER_W-1:0] reduce_letter(input logic [LETTER_W-1:0] k);
      reduce_letter = (k >= ALPHA_LEN) ? k - ALPHA_LEN : k;
   endfunction

endpackage

// ----- rtl/hill_cipher_3x3_encrypt.sv -----
// Hill cipher encryptor, 3x3 key.
// Input channel (req_): one ASCII byte per item, req_end_of_message on the
// final byte. Non-letters are dropped; letters are buffered until three are
// held, then a block of three cipher letters goes out on the rsp_ channel,
// one letter per item. At end of message a partial block is padded with 'X';
// with nothing pending a single empty item (letter_valid low) closes it.
// Key: three 15-bit row registers on the csr_ APB port at 0x0, 0x4, 0x8;
// write them only while the block is idle.
// Path: a block accepted on req_ passes the letter register, the row-sum
// register and the mod-26 / output register before it shows on rsp_.
// Throughput: one byte per cycle while req_stall is low. The output register
// holds one block and drains one letter per cycle while rsp_stall is low; two
// more blocks wait in the pipeline stages before req_stall rises.
// rsp_stall holds the current letter and backs up the stages; req_stall is
// high only when the first stage is full and cannot move on.
// Reset clears the key rows, the pending letter count and all stages.
module hill_cipher_3x3_encrypt (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_char_in,
   input  logic                         req_end_of_message,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [hc3_pkg::CHAR_W-1:0]   rsp_cipher_char,
   output logic                         rsp_letter_valid,
   output logic                         rsp_last_of_block,
   output logic                         rsp_message_done,

   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [hc3_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [hc3_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [hc3_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready
);

   localparam int BS = hc3_pkg::BLOCK_SIZE;
   localparam int LW = hc3_pkg::LETTER_W;

   // key rows
   logic [BS-1:0][hc3_pkg::KEY_W-1:0] key_ff, key_in;
   hc3_pkg::reg_index_type            csr_idx;
   logic                              csr_write;

   // pending letters
   logic [LW-1:0] pend0_ff, pend0_in, pend1_ff, pend1_in;
   logic [1:0]    pend_cnt_ff, pend_cnt_in;

   // stages
   logic             a_valid_ff, a_valid_in;
   hc3_pkg::blk_type a_blk_ff, a_blk_in;
   logic             b_valid_ff, b_valid_in;
   hc3_pkg::sum_type b_sum_ff, b_sum_in;
   logic             o_valid_ff, o_valid_in;
   logic [BS-1:0][hc3_pkg::CHAR_W-1:0] o_char_ff, o_char_in;
   logic             o_empty_ff, o_empty_in;
   logic             o_done_ff, o_done_in;
   logic [1:0]       o_idx_ff, o_idx_in;

   logic          req_fire, rsp_fire;
   logic          a_take, b_take, out_take;
   logic          is_letter;
   logic [LW-1:0] letter_val;
   logic [7:0]    char_off;
   logic          last_int;

   logic [BS-1:0][BS-1:0][LW-1:0] key_red;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = hc3_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      key_in = key_ff;
      if (csr_write) begin
         unique case (csr_idx)
            hc3_pkg::REG_KEY_ROW_ZERO: key_in[0] = csr_pwdata[hc3_pkg::KEY_W-1:0];
            hc3_pkg::REG_KEY_ROW_ONE:  key_in[1] = csr_pwdata[hc3_pkg::KEY_W-1:0];
            hc3_pkg::REG_KEY_ROW_TWO:  key_in[2] = csr_pwdata[hc3_pkg::KEY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         hc3_pkg::REG_KEY_ROW_ZERO:
            csr_prdata = {{(hc3_pkg::DATA_W-hc3_pkg::KEY_W){1'b0}}, key_ff[0]};
         hc3_pkg::REG_KEY_ROW_ONE:
            csr_prdata = {{(hc3_pkg::DATA_W-hc3_pkg::KEY_W){1'b0}}, key_ff[1]};
         hc3_pkg::REG_KEY_ROW_TWO:
            csr_prdata = {{(hc3_pkg::DATA_W-hc3_pkg::KEY_W){1'b0}}, key_ff[2]};
         default:
            csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   assign last_int  = o_empty_ff || (o_idx_ff == 2'd2);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign out_take  = !o_valid_ff || (!rsp_stall && last_int);
   assign b_take    = !b_valid_ff || out_take;
   assign a_take    = !a_valid_ff || b_take;
   assign req_stall = !a_take;
   assign req_fire  = req_valid && !req_stall;

   // ---------------- letter decode and block assembly ----------------
   always_comb begin
      is_letter = 1'b0;
      char_off  = '0;
      if (req_char_in >= hc3_pkg::UPPER_A && req_char_in <= hc3_pkg::UPPER_Z) begin
         is_letter = 1'b1;
         char_off  = req_char_in - hc3_pkg::UPPER_A;
      end else if (req_char_in >= hc3_pkg::LOWER_A && req_char_in <= hc3_pkg::LOWER_Z) begin
         is_letter = 1'b1;
         char_off  = req_char_in - hc3_pkg::LOWER_A;
      end
      letter_val = char_off[LW-1:0];
   end

   always_comb begin
      logic          fire_blk;
      logic [LW-1:0] p0_new, p1_new;
      logic [1:0]    cnt_new;

      pend0_in    = pend0_ff;
      pend1_in    = pend1_ff;
      pend_cnt_in = pend_cnt_ff;
      a_blk_in    = a_blk_ff;
      fire_blk    = 1'b0;
      p0_new      = pend0_ff;
      p1_new      = pend1_ff;
      cnt_new     = pend_cnt_ff;

      if (req_fire) begin
         if (is_letter && pend_cnt_ff == 2'd2) begin
            // third letter closes the block
            fire_blk       = 1'b1;
            a_blk_in.p     = {letter_val, pend1_ff, pend0_ff};
            a_blk_in.empty = 1'b0;
            a_blk_in.done  = req_end_of_message;
            pend_cnt_in    = 2'd0;
         end else begin
            if (is_letter) begin
               if (pend_cnt_ff == 2'd0) p0_new = letter_val;
               else                     p1_new = letter_val;
               cnt_new = pend_cnt_ff + 2'd1;
            end
            pend0_in    = p0_new;
            pend1_in    = p1_new;
            pend_cnt_in = cnt_new;
            if (req_end_of_message) begin
               fire_blk       = 1'b1;
               a_blk_in.empty = (cnt_new == 2'd0);
               a_blk_in.done  = 1'b1;
               a_blk_in.p     = {hc3_pkg::PAD_VALUE,
                                 (cnt_new == 2'd2) ? p1_new : hc3_pkg::PAD_VALUE,
                                 p0_new};
               pend_cnt_in    = 2'd0;
            end
         end
      end

      if (fire_blk)    a_valid_in = 1'b1;
      else if (b_take) a_valid_in = 1'b0;
      else             a_valid_in = a_valid_ff;
   end

   // ---------------- row sums ----------------
   always_comb begin
      for (int i = 0; i < BS; i++) begin
         for (int j = 0; j < BS; j++) begin
            key_red[i][j] = hc3_pkg::reduce_letter(key_ff[i][LW*j +: LW]);
         end
      end
   end

   always_comb begin
      b_sum_in.empty = a_blk_ff.empty;
      b_sum_in.done  = a_blk_ff.done;
      for (int i = 0; i < BS; i++) begin
         b_sum_in.sum[i] = '0;
         for (int j = 0; j < BS; j++) begin
            b_sum_in.sum[i] = b_sum_in.sum[i]
                            + hc3_pkg::SUM_W'(key_red[i][j]) * hc3_pkg::SUM_W'(a_blk_ff.p[j]);
         end
      end
      b_valid_in = b_take ? a_valid_ff : b_valid_ff;
   end

   // ---------------- mod 26 and output register ----------------
   always_comb begin
      logic [hc3_pkg::PROD_W-1:0] prod;
      logic [hc3_pkg::QUOT_W-1:0] quot;
      logic [hc3_pkg::SUM_W-1:0]  q26;
      logic [hc3_pkg::SUM_W-1:0]  rem;

      for (int i = 0; i < BS; i++) begin
         prod = hc3_pkg::PROD_W'(b_sum_ff.sum[i]) * hc3_pkg::PROD_W'(hc3_pkg::RECIP_26);
         quot = prod[hc3_pkg::PROD_W-1:hc3_pkg::RECIP_SHIFT];
         // times 26 = 16 + 8 + 2
         q26  = (hc3_pkg::SUM_W'(quot) << 4) + (hc3_pkg::SUM_W'(quot) << 3)
              + (hc3_pkg::SUM_W'(quot) << 1);
         rem  = b_sum_ff.sum[i] - q26;
         o_char_in[i] = hc3_pkg::CHAR_W'(rem[LW-1:0]) + hc3_pkg::LETTER_A;
      end

      o_valid_in = o_valid_ff;
      o_empty_in = o_empty_ff;
      o_done_in  = o_done_ff;
      o_idx_in   = o_idx_ff;
      if (out_take) begin
         o_valid_in = b_valid_ff;
         o_empty_in = b_sum_ff.empty;
         o_done_in  = b_sum_ff.done;
         o_idx_in   = 2'd0;
      end else if (rsp_fire) begin
         o_idx_in = o_idx_ff + 2'd1;
      end
   end

   always_comb begin
      logic [hc3_pkg::CHAR_W-1:0] cur;
      case (o_idx_ff)
         2'd0:    cur = o_char_ff[0];
         2'd1:    cur = o_char_ff[1];
         default: cur = o_char_ff[2];
      endcase
      rsp_valid         = o_valid_ff;
      rsp_letter_valid  = !o_empty_ff;
      rsp_cipher_char   = o_empty_ff ? '0 : cur;
      rsp_last_of_block = last_int;
      rsp_message_done  = o_done_ff && last_int;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         pend_cnt_ff <= '0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         o_valid_ff  <= 1'b0;
         o_idx_ff    <= '0;
         o_empty_ff  <= 1'b0;
         o_done_ff   <= 1'b0;
      end else begin
         key_ff      <= key_in;
         pend_cnt_ff <= pend_cnt_in;
         a_valid_ff  <= a_valid_in;
         b_valid_ff  <= b_valid_in;
         o_valid_ff  <= o_valid_in;
         o_idx_ff    <= o_idx_in;
         o_empty_ff  <= o_empty_in;
         o_done_ff   <= o_done_in;
      end
   end

   always_ff @(posedge clock) begin
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
      a_blk_ff <= a_blk_in;
      if (b_take) begin
         b_sum_ff <= b_sum_in;
      end
      if (out_take) begin
         o_char_ff <= o_char_in;
      end
   end

`ifndef SYNTH
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      o_valid_ff |-> (o_idx_ff != 2'd3) && !(o_empty_ff && o_idx_ff != 2'd0))
      else $error("output index out of range");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff != 2'd3)
      else $error("pending letter count out of range");

   a_block_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_block)
         |=> (rsp_valid && o_idx_ff == $past(o_idx_ff) + 2'd1))
      else $error("block cut short on output");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_letter_valid)
         |-> (rsp_cipher_char >= 7'd65 && rsp_cipher_char <= 7'd90))
      else $error("cipher letter out of range");
`endif

endmodule
